// ----- rtl/prq_pkg.sv -----
package prq_pkg;

    localparam int MaxChannels = 64;
    localparam int MaxWindowPositions = 256;
    localparam int ChanW = $clog2(MaxChannels);
    localparam int PosW = $clog2(MaxWindowPositions) + 1;
    localparam int AccW = 32;

    localparam logic [2:0] REG_POOL_MODE = 3'd0;
    localparam logic [2:0] REG_CHANNELS  = 3'd1;
    localparam logic [2:0] REG_IN_OFFSET = 3'd2;
    localparam logic [2:0] REG_OUT_OFFSET = 3'd3;
    localparam logic [2:0] REG_SCALE_MUL = 3'd4;
    localparam logic [2:0] REG_SCALE_SHIFT = 3'd5;
    localparam logic [2:0] REG_CLAMP_LOW = 3'd6;
    localparam logic [2:0] REG_CLAMP_HIGH = 3'd7;

    typedef struct packed {
        logic signed [7:0] sample;
        logic [5:0]        channel;
        logic              first_position;
        logic              last_position;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] pooled_value;
        logic [5:0]        out_channel;
        logic              window_done;
    } t_out_item;

endpackage

// ----- rtl/prq_ram.sv -----
module prq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/pool_requantize_s8.sv -----
// Channel  | Direction | Handshake               | Payload
// in       | input     | i_in_valid / o_in_ready | i_in  (prq_pkg::t_in_item)
// out      | output    | o_out_valid/i_out_ready | o_out (prq_pkg::t_out_item)
// cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time: an item that is not on the last position is read from its
// accumulator, then modified and written back through the one RAM port pair.
// A last-position item then goes through the bit-serial divider (33 steps, average
// mode only) and the six requantization steps.
// Reset is synchronous and active low; accumulators are not cleared.
// A result waiting in the output register does not stop the next request from
// being accepted; only the final step waits for the register to be free.
module pool_requantize_s8 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  prq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output prq_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import prq_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ACC  = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_PRE  = 4'd3;
    localparam logic [3:0] ST_SHL  = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_NDG  = 4'd6;
    localparam logic [3:0] ST_RND  = 4'd7;
    localparam logic [3:0] ST_RSH  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    localparam logic signed [63:0] Max32 = 64'sd2147483647;
    localparam logic signed [63:0] Min32 = -64'sd2147483648;

    // Configuration registers
    logic               r_mode;
    logic [6:0]         r_chans;
    logic signed [7:0]  r_in_off;
    logic signed [7:0]  r_out_off;
    logic [30:0]        r_mult;
    logic signed [5:0]  r_shift;
    logic signed [7:0]  r_clo;
    logic signed [7:0]  r_chi;

    logic [3:0]         r_state;
    t_in_item           r_item;
    logic               r_imode;
    logic [PosW-1:0]    r_pd;
    logic [PosW-1:0]    r_div;
    logic signed [31:0] r_acc;
    logic               r_neg;
    logic [32:0]        r_num;
    logic [PosW-1:0]    r_rem;
    logic [5:0]         r_cnt;
    logic signed [31:0] r_x;
    logic signed [31:0] r_v;
    logic signed [63:0] r_ab;
    logic signed [63:0] r_t;
    logic signed [32:0] r_q;
    logic signed [32:0] r_y;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [AccW-1:0]    ram_rdata;
    logic signed [31:0] rd;
    logic               accept;
    logic               closes;
    logic signed [32:0] sum;
    logic signed [31:0] n_acc;
    logic [PosW-1:0]    n_div;
    logic [32:0]        mag;
    logic [PosW-1:0]    trial;
    logic               qbit;
    logic signed [33:0] qsig;
    logic signed [34:0] xsum;
    logic [4:0]         left;
    logic signed [62:0] wsh;
    logic [5:0]         right;
    logic [33:0]        mask;
    logic signed [32:0] flo;
    logic [32:0]        rem;
    logic [32:0]        thr;
    logic signed [33:0] zsum;
    logic signed [33:0] zlo;
    logic signed [33:0] zhi;
    logic out_free;

    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    prq_ram #(.WIDTH(AccW), .DEPTH(MaxChannels)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_ACC),
        .i_waddr(r_item.channel),
        .i_wdata(n_acc),
        .i_raddr(i_in.channel),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        rd     = $signed(ram_rdata);
        closes = ({1'b0, r_item.channel} + 7'd1) == r_chans;
        sum    = 33'(rd) + 33'(r_item.sample);
        if (r_item.first_position) begin
            n_acc = 32'(r_item.sample);
        end else if (!r_imode) begin
            if (sum > 33'sd2147483647) begin
                n_acc = 32'sh7FFFFFFF;
            end else if (sum < -33'sd2147483648) begin
                n_acc = 32'sh80000000;
            end else begin
                n_acc = sum[31:0];
            end
        end else begin
            n_acc = (32'(r_item.sample) > rd) ? 32'(r_item.sample) : rd;
        end
        if (r_item.first_position) begin
            n_div = PosW'(1);
        end else if (r_pd >= PosW'(MaxWindowPositions)) begin
            n_div = PosW'(MaxWindowPositions);
        end else begin
            n_div = r_pd + PosW'(1);
        end
        mag = (n_acc[31] ? 33'(-34'(n_acc)) : 33'(n_acc)) + 33'(n_div >> 1);

        trial = {r_rem[PosW-2:0], r_num[32]};
        qbit  = trial >= r_div;

        qsig = r_imode ? 34'(r_acc) : (r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num}));
        xsum = 35'(qsig) + 35'(r_in_off);

        left = (r_shift > 6'sd0) ? r_shift[4:0] : 5'd0;
        wsh  = 63'(r_x) <<< left;

        right = (r_shift < 6'sd0) ? 6'(-r_shift) : 6'd0;
        mask  = (34'd1 << right) - 34'd1;
        flo   = r_q >>> right;
        rem   = r_q & mask[32:0];
        thr   = (mask[32:0] >> 1) + 33'(r_q[32]);

        zsum = 34'(r_y) + 34'(r_out_off);
        zlo  = (zsum < 34'(r_clo)) ? 34'(r_clo) : zsum;
        zhi  = (zlo > 34'(r_chi)) ? 34'(r_chi) : zlo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_chans     <= 7'd1;
            r_in_off    <= '0;
            r_out_off   <= '0;
            r_mult      <= 31'h40000000;
            r_shift     <= '0;
            r_clo       <= -8'sd128;
            r_chi       <= 8'sd127;
            r_state     <= ST_IDLE;
            r_pd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_POOL_MODE:   r_mode    <= i_cfg_data[0];
                    REG_CHANNELS:    r_chans   <= i_cfg_data[6:0];
                    REG_IN_OFFSET:   r_in_off  <= i_cfg_data[7:0];
                    REG_OUT_OFFSET:  r_out_off <= i_cfg_data[7:0];
                    REG_SCALE_MUL:   r_mult    <= i_cfg_data[30:0];
                    REG_SCALE_SHIFT: r_shift   <= i_cfg_data[5:0];
                    REG_CLAMP_LOW:   r_clo     <= i_cfg_data[7:0];
                    REG_CLAMP_HIGH:  r_chi     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // A new result is loaded in the same cycle that the old one leaves.
            r_out_valid <= ((r_state == ST_FIN) && out_free) ||
                           (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // The position count closes on the last channel; a closing
                    // last position ends the window.
                    if (closes) begin
                        if (r_item.last_position) begin
                            r_pd <= '0;
                        end else if (r_item.first_position) begin
                            r_pd <= PosW'(1);
                        end else if (r_pd < PosW'(MaxWindowPositions)) begin
                            r_pd <= r_pd + PosW'(1);
                        end
                    end
                    if (!r_item.last_position) begin
                        r_state <= ST_IDLE;
                    end else if (r_imode) begin
                        r_state <= ST_PRE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == 6'd32) begin
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: r_state <= ST_SHL;
                ST_SHL: r_state <= ST_MUL;
                ST_MUL: r_state <= ST_NDG;
                ST_NDG: r_state <= ST_RND;
                ST_RND: r_state <= ST_RSH;
                ST_RSH: r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_in;
            r_imode <= r_mode;
        end
        unique case (r_state)
            ST_ACC: begin
                r_acc <= n_acc;
                r_neg <= n_acc[31];
                r_num <= mag;
                r_div <= n_div;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= qbit ? trial - r_div : trial;
                r_num <= {r_num[31:0], qbit};
                r_cnt <= r_cnt + 6'd1;
            end
            ST_PRE: begin
                if (xsum > 35'sd2147483647) begin
                    r_x <= 32'sh7FFFFFFF;
                end else if (xsum < -35'sd2147483648) begin
                    r_x <= 32'sh80000000;
                end else begin
                    r_x <= xsum[31:0];
                end
            end
            ST_SHL: begin
                if (64'(wsh) > Max32) begin
                    r_v <= 32'sh7FFFFFFF;
                end else if (64'(wsh) < Min32) begin
                    r_v <= 32'sh80000000;
                end else begin
                    r_v <= wsh[31:0];
                end
            end
            ST_MUL: r_ab <= 64'(r_v) * 64'($signed({1'b0, r_mult}));
            ST_NDG: r_t <= r_ab + (r_ab[63] ? (64'sd1 - 64'sd1073741824) : 64'sd1073741824);
            ST_RND: begin
                // Division by 2^31 truncates towards zero.
                if (r_t[63]) begin
                    r_q <= 33'((r_t + 64'sd2147483647) >>> 31);
                end else begin
                    r_q <= 33'(r_t >>> 31);
                end
            end
            ST_RSH: r_y <= flo + ((rem > thr) ? 33'sd1 : 33'sd0);
            ST_FIN: begin
                if (out_free) begin
                    r_out.pooled_value <= zhi[7:0];
                    r_out.out_channel  <= r_item.channel;
                    r_out.window_done  <= closes;
                end
            end
            default: ;
        endcase
    end

    a_pd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd <= PosW'(MaxWindowPositions))
        else $error("position count beyond window limit");
    a_acc_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACC |-> $past(r_state) == ST_IDLE)
        else $error("accumulator update without a request");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result raised outside final step");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt <= 6'd32)
        else $error("divider ran past its last step");
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import prq_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    pool_requantize_s8 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Predictor copy of the register file and the per-channel state.
    logic              pool_is_max;
    logic [6:0]        chans;
    logic signed [7:0] in_offset;
    logic signed [7:0] out_offset;
    logic [30:0]       mult;
    logic signed [5:0] shift;
    logic signed [7:0] clamp_lo;
    logic signed [7:0] clamp_hi;
    logic signed [31:0] pooled_acc [MaxChannels];
    logic               acc_loaded [MaxChannels];
    int unsigned        pos_count;

    t_out_item pending_results[$];
    int        idle_pct;
    int        stall_pct;
    int        errors;
    int        requests_sent;
    int        results_seen;
    bit        hold_start;
    int        hold_len;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rescale(longint x);
        int      lsh;
        int      rsh;
        longint  v;
        longint  ab;
        longint  nudge;
        longint  q;
        longint  mask;
        longint  rem;
        longint  thr;
        lsh = (shift > 0) ? int'(shift) : 0;
        rsh = (shift < 0) ? -int'(shift) : 0;
        v = sat32(x * (64'sd1 << lsh));
        ab = v * longint'({33'd0, mult});
        nudge = (ab >= 0) ? (64'sd1 <<< 30) : (64'sd1 - (64'sd1 <<< 30));
        q = (ab + nudge) / (64'sd1 <<< 31);
        mask = (64'sd1 <<< rsh) - 1;
        rem = q & mask;
        thr = (mask >>> 1) + ((q < 0) ? 1 : 0);
        return (q >>> rsh) + ((rem > thr) ? 1 : 0);
    endfunction

    // Updates the predicted state for one accepted request and, for a last-position request, queues its result.
    function automatic void predict_pooling(t_in_item it);
        longint    acc;
        longint    val;
        longint    divisor;
        longint    half;
        bit        closes;
        t_out_item res;
        closes = ({1'b0, it.channel} + 7'd1) == chans;
        divisor = it.first_position ? 1 : longint'(pos_count) + 1;
        if (divisor > MaxWindowPositions) divisor = MaxWindowPositions;
        acc = pooled_acc[it.channel];
        if (it.first_position) acc = it.sample;
        else if (!pool_is_max) acc = sat32(acc + it.sample);
        else if (longint'(it.sample) > acc) acc = it.sample;
        pooled_acc[it.channel] = acc[31:0];
        if (it.first_position) acc_loaded[it.channel] = 1'b1;
        if (closes) begin
            if (it.first_position) pos_count = 1;
            else if (pos_count < MaxWindowPositions) pos_count++;
        end
        if (!it.last_position) return;
        if (!pool_is_max) begin
            half = divisor / 2;
            val = ((acc > 0) ? acc + half : acc - half) / divisor;
        end else begin
            val = acc;
        end
        val = sat32(val + in_offset);
        val = rescale(val) + out_offset;
        if (val < clamp_lo) val = clamp_lo;
        if (val > clamp_hi) val = clamp_hi;
        if (closes) pos_count = 0;
        res.pooled_value = val[7:0];
        res.out_channel = it.channel;
        res.window_done = closes;
        pending_results.push_back(res);
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_POOL_MODE:   pool_is_max = d[0];
            REG_CHANNELS:    chans = d[6:0];
            REG_IN_OFFSET:   in_offset = d[7:0];
            REG_OUT_OFFSET:  out_offset = d[7:0];
            REG_SCALE_MUL:   mult = d[30:0];
            REG_SCALE_SHIFT: shift = d[5:0];
            REG_CLAMP_LOW:   clamp_lo = d[7:0];
            REG_CLAMP_HIGH:  clamp_hi = d[7:0];
            default: ;
        endcase
    endfunction

    // Valid stays high after a write so back-to-back writes never drop it.
    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        i_cfg_index <= idx;
        i_cfg_data <= d;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, d);
    endtask

    task automatic write_all(logic mode, logic [6:0] ch, int io, int oo, logic [30:0] m,
                             int sh, int lo, int hi);
        write_reg(REG_POOL_MODE, {31'd0, mode});
        write_reg(REG_CHANNELS, {25'd0, ch});
        write_reg(REG_IN_OFFSET, io);
        write_reg(REG_OUT_OFFSET, oo);
        write_reg(REG_SCALE_MUL, {1'b0, m});
        write_reg(REG_SCALE_SHIFT, sh);
        write_reg(REG_CLAMP_LOW, lo);
        write_reg(REG_CLAMP_HIGH, hi);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic signed [7:0] s, logic [5:0] ch, logic f, logic l);
        t_in_item it;
        it.sample = s;
        it.channel = ch;
        it.first_position = f;
        it.last_position = l;
        // An accumulator that was never loaded must not be read.
        if (!acc_loaded[ch]) it.first_position = 1'b1;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pooling(it);
        requests_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic signed [7:0] rand_sample();
        case ($urandom_range(7))
            0: return 8'sh7f;
            1: return 8'sh80;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic send_window(int nch, int npos, bit extreme);
        for (int p = 0; p < npos; p++) begin
            for (int c = 0; c < nch; c++) begin
                send_item(extreme ? ((p + c) % 2 ? 8'sh7f : 8'sh80) : rand_sample(),
                          c[5:0], p == 0, p == npos - 1);
            end
        end
    endtask

    task automatic random_config();
        int  nch;
        int  sh;
        int  lo;
        int  hi;
        logic [30:0] m;
        nch = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 8);
        sh = ($urandom_range(4) == 0) ? $urandom_range(0, 62) - 31 : $urandom_range(0, 12) - 10;
        case ($urandom_range(3))
            0: m = 31'h7fffffff;
            1: m = 31'd0;
            default: m = 31'($urandom());
        endcase
        lo = $urandom_range(0, 80) - 128;
        hi = 127 - $urandom_range(0, 80);
        if ($urandom_range(9) == 0) begin
            lo = $urandom_range(0, 255) - 128;
            hi = $urandom_range(0, 255) - 128;
        end
        write_all(1'($urandom_range(1)), nch[6:0], $urandom_range(0, 255) - 128,
                  $urandom_range(0, 255) - 128, m, sh, lo, hi);
    endtask

    task automatic test_directed();
        write_all(1'b0, 7'd1, 0, 0, 31'h40000000, 0, -128, 127);
        send_item(8'sh7f, 6'd0, 1'b1, 1'b1);
        send_item(8'sh80, 6'd0, 1'b1, 1'b1);
        drain();
        write_all(1'b0, 7'd2, 127, -128, 31'h7fffffff, 31, -128, 127);
        send_window(2, 3, 1'b1);
        drain();
        write_all(1'b1, 7'd2, -128, 127, 31'h7fffffff, -31, 10, -10);
        send_window(2, 2, 1'b1);
        drain();
        // Mode switched halfway through a window.
        write_all(1'b0, 7'd1, 0, 0, 31'h40000000, 0, -128, 127);
        send_item(8'sd5, 6'd0, 1'b1, 1'b0);
        drain();
        write_reg(REG_POOL_MODE, 32'd1);
        i_cfg_valid <= 1'b0;
        send_item(-8'sd9, 6'd0, 1'b0, 1'b1);
        drain();
        // No channel closes a position when the channel count is out of range.
        write_reg(REG_CHANNELS, 32'd0);
        i_cfg_valid <= 1'b0;
        send_item(8'sd3, 6'd0, 1'b1, 1'b0);
        send_item(8'sd4, 6'd0, 1'b0, 1'b1);
        drain();
        write_reg(REG_CHANNELS, 32'd100);
        i_cfg_valid <= 1'b0;
        send_item(8'sd7, 6'd63, 1'b1, 1'b1);
        drain();
    endtask

    // Saturation of the position counter needs more than the largest divisor.
    task automatic test_long_window();
        write_all(1'b0, 7'd1, -3, 2, 31'h5a5a5a5a, 1, -128, 127);
        send_window(1, 300, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        write_all(1'b1, 7'd4, 0, 0, 31'h40000000, 0, -128, 127);
        hold_len = 500;
        hold_start = 1'b1;
        for (int w = 0; w < 25; w++) send_window(4, 1, 1'b0);
        drain();
    endtask

    task automatic test_random(int idle, int stall, int n_items);
        int target;
        idle_pct = idle;
        stall_pct = stall;
        target = requests_sent + n_items;
        while (requests_sent < target) begin
            random_config();
            repeat ($urandom_range(2, 6)) begin
                if (requests_sent >= target) break;
                if ($urandom_range(9) < 8) begin
                    send_window(int'(chans), $urandom_range(1, 5), 1'b0);
                end else begin
                    repeat ($urandom_range(1, 10))
                        send_item(rand_sample(), 6'($urandom_range(0, 63)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
            drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            i_out_ready <= 1'b0;
        end else if (hold_len > 0) begin
            hold_len = hold_len - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %p", o_out);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out.pooled_value !== exp_res.pooled_value) begin
                    $error("pooled_value expected %0d got %0d",
                           exp_res.pooled_value, o_out.pooled_value);
                    errors++;
                end
                if (o_out.out_channel !== exp_res.out_channel) begin
                    $error("out_channel expected %0d got %0d",
                           exp_res.out_channel, o_out.out_channel);
                    errors++;
                end
                if (o_out.window_done !== exp_res.window_done) begin
                    $error("window_done expected %0d got %0d",
                           exp_res.window_done, o_out.window_done);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_POOL_MODE;
        i_cfg_data = '0;
        hold_start = 1'b0;
        hold_len = 0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        pos_count = 0;
        for (int c = 0; c < MaxChannels; c++) begin
            pooled_acc[c] = '0;
            acc_loaded[c] = 1'b0;
        end
        pool_is_max = 1'b0;
        chans = 7'd1;
        in_offset = '0;
        out_offset = '0;
        mult = 31'h40000000;
        shift = '0;
        clamp_lo = -8'sd128;
        clamp_hi = 8'sd127;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_window();
        test_backpressure();
        test_random(0, 0, 250);
        test_random(68, 0, 250);
        test_random(0, 68, 250);
        test_random(38, 38, 250);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d requests and %0d results over average and max pooling,",
                 requests_sent, results_seen);
        $display("random register settings, idle and stall phases and a long output hold.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
